[rtl/cct_pkg.sv]
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types, codes and constants of the four-channel cascade timer.
// ----------------------------------------------------------------------------
package cct_pkg;

  localparam int TICK_WIDTH_DEF = 12;
  localparam int NUM_CH         = 4;
  localparam int CH_W           = 2;
  localparam int CNT_W          = 16;
  localparam int RESID_W        = 10;
  localparam int FUNC_W         = 2;
  localparam int ADDR_W         = 4;
  localparam int MASK_W         = 4;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

  localparam int CTL_PRESCALE_LSB = 0;
  localparam int CTL_CASCADE_BIT  = 2;
  localparam int CTL_IRQ_BIT      = 6;
  localparam int CTL_ENABLE_BIT   = 7;
  localparam int ADDR_SEL_CTL_BIT = 1;
  localparam int ADDR_CH_LSB      = 2;

  // prescaler divides by 1, 64, 256, 1024
  function automatic logic [3:0] prescale_shift(input logic [1:0] sel);
    logic [3:0] sh;
    case (sel)
      2'd0:    sh = 4'd0;
      2'd1:    sh = 4'd6;
      2'd2:    sh = 4'd8;
      2'd3:    sh = 4'd10;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

  typedef struct packed {
    logic            capture;
    logic            exec;
    logic            load;
    logic            cmp;
    logic            div_step;
    logic            fin;
    logic            publish;
    logic [CH_W-1:0] ch;
  } cct_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } cct_stat_t;

endpackage

[rtl/cct_in_if.sv]
// ----------------------------------------------------------------------------
// cct_in_if
// Input word channel: tick, register read or register write.
// ----------------------------------------------------------------------------
interface cct_in_if import cct_pkg::*; #(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [TICK_WIDTH-1:0] tick_cycles;
  logic [ADDR_W-1:0]     reg_addr;
  logic [CNT_W-1:0]      write_data;

  modport source (output valid, output func, output tick_cycles, output reg_addr,
                  output write_data, input ready);
  modport sink   (input valid, input func, input tick_cycles, input reg_addr,
                  input write_data, output ready);
endinterface

[rtl/cct_out_if.sv]
// ----------------------------------------------------------------------------
// cct_out_if
// Result word channel: read data, overflow and interrupt masks.
// ----------------------------------------------------------------------------
interface cct_out_if import cct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  read_data;
  logic [MASK_W-1:0] overflow_mask;
  logic [MASK_W-1:0] irq_request;

  modport source (output valid, output read_data, output overflow_mask,
                  output irq_request, input ready);
  modport sink   (input valid, input read_data, input overflow_mask,
                  input irq_request, output ready);
endinterface

[rtl/cct_ctrl.sv]
// ----------------------------------------------------------------------------
// cct_ctrl
// Sequencer: runs a read or write word, or walks the four channels of a tick,
// running the divider on overflow, and hands the result to the output register.
// ----------------------------------------------------------------------------
module cct_ctrl import cct_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  cct_stat_t         stat,
  output cct_cmd_t          cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

  logic [2:0]      state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic            out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    cmd       = '0;
    cmd.ch    = ch_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          ch_nxt      = '0;
          state_nxt   = (in_func == FUNC_TICK) ? S_LOAD : S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (stat.need_div) begin
          state_nxt = S_DIV;
        end else if (ch_r == LAST_CH) begin
          state_nxt = S_DONE;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (ch_r == LAST_CH) begin
          state_nxt = S_DONE;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/cct_datapath.sv]
// ----------------------------------------------------------------------------
// cct_datapath
// Channel registers, prescaler, overflow compare, shared restoring divider
// for the reload period, and the result and output registers.
// ----------------------------------------------------------------------------
module cct_datapath import cct_pkg::*; #(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cct_cmd_t              cmd,
  output cct_stat_t             stat,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [TICK_WIDTH-1:0] in_tick_cycles,
  input  logic [ADDR_W-1:0]     in_reg_addr,
  input  logic [CNT_W-1:0]      in_write_data,
  output logic [CNT_W-1:0]      out_read_data,
  output logic [MASK_W-1:0]     out_overflow_mask,
  output logic [MASK_W-1:0]     out_irq_request
);

  localparam int SUM_W  = ((TICK_WIDTH > RESID_W) ? TICK_WIDTH : RESID_W) + 1;
  localparam int DIF_W  = ((SUM_W > CNT_W + 1) ? SUM_W : CNT_W + 1) + 1;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam logic [CNT_W:0]       CNT_SPAN = {1'b1, {CNT_W{1'b0}}};
  localparam logic [DCNT_W-1:0]    DIV_LAST = DCNT_W'(SUM_W - 1);

  // channel state
  logic [CNT_W-1:0]   cnt_r [NUM_CH];
  logic [CNT_W-1:0]   rel_r [NUM_CH];
  logic [CNT_W-1:0]   ctl_r [NUM_CH];
  logic [RESID_W-1:0] res_r [NUM_CH];

  // captured word and work registers
  logic [FUNC_W-1:0]     func_r;
  logic [TICK_WIDTH-1:0] cyc_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [CNT_W-1:0]      wdata_r;
  logic [SUM_W-1:0]      n_r;
  logic [SUM_W-1:0]      prev_r;
  logic [SUM_W-1:0]      q_r;
  logic [CNT_W:0]        rem_r;
  logic [DCNT_W-1:0]     dcnt_r;
  logic [CNT_W-1:0]      rd_r;
  logic [MASK_W-1:0]     ovf_r;
  logic [MASK_W-1:0]     irq_r;
  logic [CNT_W-1:0]      out_rd_r;
  logic [MASK_W-1:0]     out_ovf_r;
  logic [MASK_W-1:0]     out_irq_r;

  logic [CH_W-1:0]    idx;
  logic [CNT_W-1:0]   ctl, cnt, rel;
  logic [RESID_W-1:0] res;
  logic               en, casc, sel_ctl;
  logic [3:0]         shift;
  logic [SUM_W-1:0]   sum, n_load;
  logic [RESID_W:0]   div_span;
  logic [RESID_W-1:0] res_load;
  logic [CNT_W:0]     first, period;
  logic [DIF_W-1:0]   diff;
  logic               borrow, n_zero;
  logic [SUM_W-1:0]   rest;
  logic [CNT_W+1:0]   partial, trial;
  logic               take;
  logic [CNT_W-1:0]   cnt_small;

  assign idx     = cmd.exec ? addr_r[ADDR_CH_LSB +: CH_W] : cmd.ch;
  assign ctl     = ctl_r[idx];
  assign cnt     = cnt_r[idx];
  assign rel     = rel_r[idx];
  assign res     = res_r[idx];
  assign en      = ctl[CTL_ENABLE_BIT];
  assign casc    = ctl[CTL_CASCADE_BIT] && (idx != '0);
  assign sel_ctl = addr_r[ADDR_SEL_CTL_BIT];

  // prescaler
  assign shift    = prescale_shift(ctl[CTL_PRESCALE_LSB +: 2]);
  assign sum      = SUM_W'(res) + SUM_W'(cyc_r);
  assign n_load   = casc ? prev_r : (sum >> shift);
  assign div_span = (RESID_W + 1)'(1) << shift;
  assign res_load = sum[RESID_W-1:0] & RESID_W'(div_span - 1'b1);

  // overflow compare
  assign first     = CNT_SPAN - {1'b0, cnt};
  assign period    = CNT_SPAN - {1'b0, rel};
  assign diff      = DIF_W'(n_r) - DIF_W'(first);
  assign borrow    = diff[DIF_W-1];
  assign n_zero    = (n_r == '0);
  assign rest      = diff[SUM_W-1:0];
  assign cnt_small = cnt + n_r[CNT_W-1:0];

  // restoring divider step
  assign partial = {rem_r, q_r[SUM_W-1]};
  assign trial   = partial - {1'b0, period};
  assign take    = !trial[CNT_W+1];

  assign stat.need_div = en && !n_zero && !borrow;
  assign stat.div_last = (dcnt_r == DIV_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        cnt_r[i] <= '0;
        rel_r[i] <= '0;
        ctl_r[i] <= '0;
        res_r[i] <= '0;
      end
    end else begin
      if (cmd.exec && (func_r == FUNC_WRITE)) begin
        if (sel_ctl) begin
          ctl_r[idx] <= wdata_r;
          if (!ctl[CTL_ENABLE_BIT] && wdata_r[CTL_ENABLE_BIT]) begin
            cnt_r[idx] <= rel;
            res_r[idx] <= '0;
          end
        end else begin
          rel_r[idx] <= wdata_r;
          cnt_r[idx] <= wdata_r;
        end
      end
      if (cmd.load && en && !casc) begin
        res_r[idx] <= res_load;
      end
      if (cmd.cmp && !stat.need_div && en && !n_zero) begin
        cnt_r[idx] <= cnt_small;
      end
      if (cmd.fin) begin
        cnt_r[idx] <= rel + rem_r[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      cyc_r   <= in_tick_cycles;
      addr_r  <= in_reg_addr;
      wdata_r <= in_write_data;
      prev_r  <= '0;
      rd_r    <= '0;
      ovf_r   <= '0;
      irq_r   <= '0;
    end
    if (cmd.exec && (func_r == FUNC_READ)) begin
      rd_r <= sel_ctl ? ctl : cnt;
    end
    if (cmd.load) begin
      n_r <= en ? n_load : '0;
    end
    if (cmd.cmp) begin
      if (stat.need_div) begin
        q_r    <= rest;
        rem_r  <= '0;
        dcnt_r <= '0;
      end else begin
        prev_r <= '0;
      end
    end
    if (cmd.div_step) begin
      q_r    <= {q_r[SUM_W-2:0], take};
      rem_r  <= take ? trial[CNT_W:0] : partial[CNT_W:0];
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.fin) begin
      prev_r     <= q_r + 1'b1;
      ovf_r[idx] <= 1'b1;
      if (ctl[CTL_IRQ_BIT]) begin
        irq_r[idx] <= 1'b1;
      end
    end
    if (cmd.publish) begin
      out_rd_r  <= rd_r;
      out_ovf_r <= ovf_r;
      out_irq_r <= irq_r;
    end
  end

  assign out_read_data     = out_rd_r;
  assign out_overflow_mask = out_ovf_r;
  assign out_irq_request   = out_irq_r;

endmodule

[rtl/four_channel_cascade_timer_unit.sv]
// ----------------------------------------------------------------------------
// four_channel_cascade_timer_unit
// A read or write word is captured, executed and sent to the output register.
// A tick runs a load and a compare step per channel; each channel that overflows
// adds the shared one-bit-per-cycle period divider's steps and a finish step.
// One word is worked on at a time; the next is taken once the result sits in
// the output register. Synchronous reset clears all channel registers.
// ----------------------------------------------------------------------------
module four_channel_cascade_timer_unit import cct_pkg::*; #(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cct_in_if.sink    in_ch,
  cct_out_if.source out_ch
);

  cct_cmd_t  cmd;
  cct_stat_t stat;

  cct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  cct_datapath #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_func           (in_ch.func),
    .in_tick_cycles    (in_ch.tick_cycles),
    .in_reg_addr       (in_ch.reg_addr),
    .in_write_data     (in_ch.write_data),
    .out_read_data     (out_ch.read_data),
    .out_overflow_mask (out_ch.overflow_mask),
    .out_irq_request   (out_ch.irq_request)
  );

endmodule
